FILE: rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// rhc_pkg: widths, pipeline geometry and the stage payload type
// of the rgb to hsl converter; no dependencies
package rhc_pkg;

  localparam int CH_W    = 8;                 // channel and output field width
  localparam int SUM_W   = CH_W + 1;          // max + min
  localparam int HNUM_W  = CH_W + 3;          // hue numerator and 6*chroma
  localparam int HREM_W  = HNUM_W + CH_W;     // 255 * hue numerator
  localparam int SREM_W  = 2 * CH_W;          // 255 * chroma
  localparam int Q_W     = CH_W;              // quotient width

  localparam int DIV_FIRST    = 2;            // first divider stage
  localparam int BITS_PER_STG = 2;            // quotient bits per divider stage
  localparam int NSTG         = DIV_FIRST + Q_W / BITS_PER_STG;

  typedef struct packed {
    logic [HREM_W-1:0] hrem;    // hue dividend, then partial remainder
    logic [HNUM_W-1:0] hdiv;    // hue divisor, 6*chroma, never zero
    logic [SREM_W-1:0] srem;    // saturation dividend, then partial remainder
    logic [CH_W-1:0]   sdiv;    // saturation divisor, never zero
    logic [Q_W-1:0]    hq;      // hue quotient bits
    logic [Q_W-1:0]    sq;      // saturation quotient bits
    logic [CH_W-1:0]   light;   // lightness, final after the first stage
  } pipe_t;

endpackage

FILE: rtl/rhc_rgb_if.sv
`timescale 1ns / 1ps
// rhc_rgb_if: valid/ready channel carrying one rgb pixel per beat
// depends on rhc_pkg
interface rhc_rgb_if;
  logic                   valid;
  logic                   ready;
  logic [rhc_pkg::CH_W-1:0] red;
  logic [rhc_pkg::CH_W-1:0] green;
  logic [rhc_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/rhc_hsl_if.sv
`timescale 1ns / 1ps
// rhc_hsl_if: valid/ready channel carrying one hsl result per beat
// depends on rhc_pkg
interface rhc_hsl_if;
  logic                   valid;
  logic                   ready;
  logic [rhc_pkg::CH_W-1:0] hue;
  logic [rhc_pkg::CH_W-1:0] saturation;
  logic [rhc_pkg::CH_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

FILE: rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// rgb_to_hsl_converter: 6-stage pipeline from input beat to result, throughput
// one pixel per cycle when not stalled; both divides are restoring dividers that
// resolve two quotient bits per stage over four stages, running side by side
// each stage holds its beat while the stage after it is full and stalled
// synchronous active-low reset clears all stage valid bits; payload is not reset
// depends on rhc_pkg, rhc_rgb_if, rhc_hsl_if
module rgb_to_hsl_converter (
  input  logic             clk,
  input  logic             rst_n,
  rhc_rgb_if.sink          in_px,
  rhc_hsl_if.source        out_px
);
  import rhc_pkg::*;

  pipe_t            st_r   [NSTG];
  pipe_t            st_nxt [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  rdy;

  // stage 0: max, min, sector, hue numerator, divisors and lightness
  always_comb begin
    logic [CH_W-1:0]   r, g, b, mx, mn, ch, den;
    logic [SUM_W-1:0]  sum, fold;
    logic [HNUM_W:0]   six, num, r1, g1, b1, ch1;
    logic              red_max, grn_max;
    r = in_px.red;
    g = in_px.green;
    b = in_px.blue;
    red_max = (r >= g) && (r >= b);
    grn_max = !red_max && (g >= b);
    mx = red_max ? r : (grn_max ? g : b);
    mn = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
    sum = {1'b0, mx} + {1'b0, mn};
    ch  = mx - mn;
    r1  = (HNUM_W + 1)'(r);
    g1  = (HNUM_W + 1)'(g);
    b1  = (HNUM_W + 1)'(b);
    ch1 = (HNUM_W + 1)'(ch);
    six = (ch1 << 2) + (ch1 << 1);
    if (red_max) begin
      // negative red-sector hue wraps by a full circle
      num = (g >= b) ? (g1 - b1) : (six - (b1 - g1));
    end else if (grn_max) begin
      num = (ch1 << 1) + b1 - r1;
    end else begin
      num = (ch1 << 2) + r1 - g1;
    end
    // min(sum, 2F - sum)
    fold = sum[SUM_W-1] ? (SUM_W'(2 * ((1 << CH_W) - 1)) - sum) : sum;
    den  = fold[CH_W-1:0];

    st_nxt[0]       = '0;
    st_nxt[0].hrem  = HREM_W'(num[HNUM_W-1:0]);
    // gray or black/white: dividend is zero, a divisor of one keeps the quotient zero
    st_nxt[0].hdiv  = (ch == '0) ? HNUM_W'(1) : six[HNUM_W-1:0];
    st_nxt[0].srem  = SREM_W'(ch);
    st_nxt[0].sdiv  = (den == '0) ? CH_W'(1) : den;
    st_nxt[0].light = sum[SUM_W-1:1];
  end

  // stage 1: scale both dividends by 255
  always_comb begin
    st_nxt[1]      = st_r[0];
    st_nxt[1].hrem = (st_r[0].hrem << CH_W) - st_r[0].hrem;
    st_nxt[1].srem = (st_r[0].srem << CH_W) - st_r[0].srem;
  end

  // divider stages, quotient msb first
  for (genvar k = DIV_FIRST; k < NSTG; k++) begin : g_div
    localparam int HI = Q_W - 1 - BITS_PER_STG * (k - DIV_FIRST);
    always_comb begin
      logic [HREM_W-1:0] hd;
      logic [SREM_W-1:0] sd;
      st_nxt[k] = st_r[k-1];
      for (int j = 0; j < BITS_PER_STG; j++) begin
        hd = HREM_W'(st_nxt[k].hdiv) << (HI - j);
        sd = SREM_W'(st_nxt[k].sdiv) << (HI - j);
        if (st_nxt[k].hrem >= hd) begin
          st_nxt[k].hrem         = st_nxt[k].hrem - hd;
          st_nxt[k].hq[HI - j]   = 1'b1;
        end
        if (st_nxt[k].srem >= sd) begin
          st_nxt[k].srem         = st_nxt[k].srem - sd;
          st_nxt[k].sq[HI - j]   = 1'b1;
        end
      end
    end
  end

  // a stage takes a beat when it is empty or its contents move on
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k == NSTG - 1) begin : g_last
      assign rdy[k] = !vld_r[k] || out_px.ready;
    end else begin : g_mid
      assign rdy[k] = !vld_r[k] || rdy[k+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= (k == 0) ? in_px.valid : vld_r[(k == 0) ? 0 : k - 1];
      end
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign in_px.ready       = rdy[0];
  assign out_px.valid      = vld_r[NSTG-1];
  assign out_px.hue        = st_r[NSTG-1].hq;
  assign out_px.saturation = st_r[NSTG-1].sq;
  assign out_px.lightness  = st_r[NSTG-1].light;

  // reset empties the whole pipeline
  assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  // an accepted beat always lands in stage 0
  assert property (@(posedge clk) disable iff (!rst_n)
    in_px.valid && in_px.ready |=> vld_r[0])
    else $error("accepted beat lost at stage 0");

  // divisors never reach the divider as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> st_r[0].hdiv != '0 && st_r[0].sdiv != '0)
    else $error("zero divisor entered pipeline");

  // after the last divider stage both remainders are below their divisors
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> st_r[NSTG-1].hrem < HREM_W'(st_r[NSTG-1].hdiv)
                   && st_r[NSTG-1].srem < SREM_W'(st_r[NSTG-1].sdiv))
    else $error("divider remainder out of range");

  // a full circle never shows as hue
  assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> out_px.hue != {CH_W{1'b1}})
    else $error("hue reached full circle");

endmodule

FILE: dv/rgb_to_hsl_converter_checker.sv
`timescale 1ns / 1ps
// rgb_to_hsl_converter_checker: watches the pixel and result channels, predicts hsl per pixel
// and compares in order; depends on rhc_pkg, rhc_rgb_if, rhc_hsl_if
module rgb_to_hsl_converter_checker
  import rhc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rhc_rgb_if   px_in,
  rhc_hsl_if   px_out,
  output int   fail_count,
  output int   pending,
  output int   compared
);

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] lightness;
  } hsl_due_t;

  localparam int unsigned FULL = (1 << CH_W) - 1;

  hsl_due_t hsl_due[$];

  function automatic hsl_due_t hsl_of_pixel(input logic [CH_W-1:0] r, g, b);
    int unsigned ri, gi, bi, mx, mn, sum, chroma, six, num, den;
    hsl_due_t res;
    ri = 32'(r);
    gi = 32'(g);
    bi = 32'(b);
    mx = (ri > gi) ? ri : gi;
    mx = (bi > mx) ? bi : mx;
    mn = (ri < gi) ? ri : gi;
    mn = (bi < mn) ? bi : mn;
    sum = mx + mn;
    chroma = mx - mn;
    six = 6 * chroma;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.lightness = CH_W'((255 * sum) / (2 * FULL));
    res.saturation = '0;
    if (sum != 0 && sum != 2 * FULL) begin
      den = (sum < 2 * FULL - sum) ? sum : 2 * FULL - sum;
      res.saturation = CH_W'((255 * chroma) / den);
    end
    res.hue = '0;
    if (chroma != 0) begin
      // ties resolve red first, then green
      if (mx == ri)
        num = (gi >= bi) ? gi - bi : six - (bi - gi);
      else if (mx == gi)
        num = 2 * chroma + bi - ri;
      else
        num = 4 * chroma + ri - gi;
      res.hue = CH_W'((255 * num) / six);
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    compared = 0;
  end

  always @(posedge clk) begin : watch
    hsl_due_t want;
    if (rst_n) begin
      if (px_in.valid && px_in.ready)
        hsl_due.push_back(hsl_of_pixel(px_in.red, px_in.green, px_in.blue));
      if (px_out.valid && px_out.ready) begin
        if (hsl_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing expected: h=%0d s=%0d l=%0d", $realtime,
                     px_out.hue, px_out.saturation, px_out.lightness);
        end else begin
          want = hsl_due.pop_front();
          compared++;
          if (px_out.hue !== want.hue || px_out.saturation !== want.saturation ||
              px_out.lightness !== want.lightness) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: rgb %0d,%0d,%0d expected h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
                       $realtime, want.red, want.green, want.blue, want.hue,
                       want.saturation, want.lightness, px_out.hue, px_out.saturation,
                       px_out.lightness);
          end
        end
      end
      pending = hsl_due.size();
    end
  end

endmodule

FILE: dv/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 1ps
// rgb_to_hsl_converter_tb: drives pixels and result back-pressure into the converter, checks
// via rgb_to_hsl_converter_checker; depends on rhc_pkg, rhc_rgb_if, rhc_hsl_if and the rtl
module rgb_to_hsl_converter_tb;
  import rhc_pkg::*;

  localparam int RAND_PER_PHASE = 560;
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   compared;
  int   src_idle_pct;
  int   sink_idle_pct;
  logic hold_req;
  int   sent;
  int   directed;

  rhc_rgb_if in_px();
  rhc_hsl_if out_px();

  rgb_to_hsl_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px)
  );

  rgb_to_hsl_converter_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .px_in      (in_px),
    .px_out     (out_px),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_px.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_px.ready = (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // offer one pixel beat and wait until it is taken
  task automatic send_px(input logic [CH_W-1:0] r, g, b);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_px.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_px.valid = 1'b1;
    in_px.red   = r;
    in_px.green = g;
    in_px.blue  = b;
    do @(posedge clk); while (!in_px.ready);
    sent++;
  endtask

  function automatic logic [CH_W-1:0] edge_val();
    case ($urandom_range(3))
      0: return '0;
      1: return CH_W'(1);
      2: return CH_W'({CH_W{1'b1}} - 1);
      default: return {CH_W{1'b1}};
    endcase
  endfunction

  task automatic send_rand_px();
    logic [CH_W-1:0] r, g, b, v;
    r = CH_W'($urandom);
    g = CH_W'($urandom);
    b = CH_W'($urandom);
    v = CH_W'($urandom);
    case ($urandom_range(9))
      0: begin r = v; g = v; b = v; end                      // gray
      1: begin r = v; g = v; end                             // red/green tie
      2: begin g = v; b = v; end                             // green/blue tie
      3: begin r = edge_val(); g = edge_val(); b = edge_val(); end
      4: begin                                               // red max, blue over green
        r = {CH_W{1'b1}} - CH_W'($urandom_range(15));
        g = CH_W'($urandom_range(r));
        b = CH_W'($urandom_range(r));
        if (b < g) begin v = b; b = g; g = v; end
      end
      default: ;
    endcase
    send_px(r, g, b);
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_px.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_px.valid = 1'b0;
    in_px.red = '0;
    in_px.green = '0;
    in_px.blue = '0;
    hold_req = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    send_px(8'd0,   8'd0,   8'd0);      // black
    send_px(8'd255, 8'd255, 8'd255);    // white
    send_px(8'd128, 8'd128, 8'd128);    // gray
    send_px(8'd255, 8'd0,   8'd0);
    send_px(8'd0,   8'd255, 8'd0);
    send_px(8'd0,   8'd0,   8'd255);
    send_px(8'd255, 8'd0,   8'd1);      // red sector wraps
    send_px(8'd255, 8'd0,   8'd254);
    send_px(8'd255, 8'd255, 8'd0);      // red/green tie
    send_px(8'd0,   8'd255, 8'd255);    // green/blue tie
    send_px(8'd255, 8'd0,   8'd255);    // red/blue tie
    send_px(8'd1,   8'd0,   8'd0);      // lowest nonzero sum
    send_px(8'd255, 8'd254, 8'd254);    // highest non-white sum
    send_px(8'd254, 8'd255, 8'd255);
    send_px(8'd200, 8'd100, 8'd50);
    send_px(8'd50,  8'd200, 8'd100);
    send_px(8'd100, 8'd50,  8'd200);
    send_px(8'hAA,  8'h55,  8'hAA);
    send_px(8'h55,  8'hAA,  8'h55);
    send_px(8'd127, 8'd128, 8'd129);
    send_px(8'd1,   8'd2,   8'd3);
    directed = sent;
    drain_wait();

    src_idle_pct = 34;
    sink_idle_pct = 70;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      if (i == RAND_PER_PHASE / 2) hold_req = 1'b1;
      send_rand_px();
    end
    // sender sits out until all results are back
    drain_wait();

    src_idle_pct = 70;
    sink_idle_pct = 34;
    for (int i = 0; i < RAND_PER_PHASE; i++) send_rand_px();
    drain_wait();

    // back to back, with a hold-off so the pipeline fills and stalls the input
    src_idle_pct = 0;
    sink_idle_pct = 0;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      if (i == 40) hold_req = 1'b1;
      send_rand_px();
    end
    drain_wait();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("pixels sent: %0d (%0d directed), incl. gray, black/white, ties and hue wrap",
             sent, directed);
    $display("results compared: %0d, under three stall profiles and two long hold-offs",
             compared);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
